[design/dffd_pkg.sv]
// Shared types and constants for the dual format frame demux.
package dffd_pkg;

    localparam logic [1:0] MODE_LINK   = 2'd0;
    localparam logic [1:0] MODE_RSHORT = 2'd1;
    localparam logic [1:0] MODE_RFRAME = 2'd2;
    localparam logic [1:0] MODE_GAP    = 2'd3;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_SHORT     = 3'd1;
    localparam logic [2:0] EV_TRANSPORT = 3'd2;
    localparam logic [2:0] EV_ERROR     = 3'd3;
    localparam logic [2:0] EV_SBEGIN    = 3'd4;
    localparam logic [2:0] EV_SBYTE     = 3'd5;
    localparam logic [2:0] EV_SCOMMIT   = 3'd6;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_LEN  = 2'd1;
    localparam logic [1:0] ERR_CRC  = 2'd2;

    localparam logic [1:0] PH_WAIT      = 2'd0;
    localparam logic [1:0] PH_SHORT     = 2'd1;
    localparam logic [1:0] PH_TRANSPORT = 2'd2;
    localparam logic [1:0] PH_STREAM    = 2'd3;

    localparam logic [7:0]  SYNC_BYTE = 8'h55;
    localparam logic [7:0]  SHORT_MIN = 8'd5;
    localparam logic [7:0]  SHORT_MAX = 8'd64;
    localparam logic [15:0] CRC_SEED  = 16'hffff;
    localparam logic [16:0] ENVELOPE  = 17'd6;

    localparam logic CFG_STREAM_CH = 1'b0;
    localparam logic CFG_MAX_LEN   = 1'b1;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [1:0]  error_kind;
        logic [15:0] frame_length;
        logic [7:0]  channel;
        logic [7:0]  stream_byte;
        logic [7:0]  read_data;
        logic [31:0] crc_mismatch_count;
    } result_t;

    // Per-request control passed from the parser stage to the output stage
    typedef struct packed {
        logic       valid;
        logic       rd_short;
        logic       rd_frame;
        logic       rd_zero;
        result_t    res;
    } stage_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] d;
        begin
            d = b ^ crc[7:0];
            d = d ^ {d[3:0], 4'd0};
            crc_byte = {d, crc[15:8]} ^ {12'd0, d[7:4]} ^ {5'd0, d, 3'd0};
        end
    endfunction

endpackage

[design/dffd_stores.sv]
// Short and transport frame byte stores, synchronous (registered) read.
module dffd_stores #(
    parameter int FRAME_AW = 10,
    parameter int SHORT_AW = 6
) (
    input  logic                clk,
    input  logic                s_we,
    input  logic [SHORT_AW-1:0] s_waddr,
    input  logic [7:0]          s_wdata,
    input  logic                f_we,
    input  logic [FRAME_AW-1:0] f_waddr,
    input  logic [7:0]          f_wdata,
    input  logic                rd_en,
    input  logic [SHORT_AW-1:0] s_raddr,
    input  logic [FRAME_AW-1:0] f_raddr,
    output logic [7:0]          s_rdata,
    output logic [7:0]          f_rdata
);
    logic [7:0] short_mem [2**SHORT_AW];
    logic [7:0] frame_mem [2**FRAME_AW];

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            short_mem[s_waddr] <= s_wdata;
        end
        if (rd_en)
        begin
            s_rdata <= short_mem[s_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            frame_mem[f_waddr] <= f_wdata;
        end
        if (rd_en)
        begin
            f_rdata <= frame_mem[f_raddr];
        end
    end
endmodule

[design/dual_format_frame_demux.sv]
// Top level of the dual format frame demux.
// Requests enter on s_axis (tdata: mode, data_byte, read_index from bit 0 up).
// Link bytes (mode 0) drive the frame parser; modes 1 and 2 read the short or
// transport store; mode 3 is an idle-gap reset. Every request yields exactly
// one result on m_axis. Header bytes (length, channel) and the trailing CRC
// bytes are kept in registers, so only store reads use the memories.
// The parser updates state and issues the store read in the cycle the request
// is taken; the staged result then moves into the output register with the
// read data merged. Throughput is one request per cycle while the output is not
// stalled, set by the single write and read port of each store.
// While the output register holds an untaken result and the stage register is
// full, the pipeline advances only if a result is being taken; s_axis_tready
// follows m_axis_tready through one internal stage so a stall loses nothing.
// Reset (rst_n low) returns to waiting, clears counters, streaming_channel to 0
// and max_frame_len to 1024. Store contents are undefined until written.
// Configuration: cfg_index 0 streaming_channel, 1 max_frame_len (cfg_data).
module dual_format_frame_demux #(
    parameter int FRAME_STORE_BYTES = 1024,
    parameter int SHORT_STORE_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // mode[1:0], data_byte[9:2], read_index[19:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_res[2:0], error_kind[4:3], frame_length[20:5], channel[28:21],
    // stream_byte[36:29], read_data[44:37], crc_mismatch_count[76:45]
    output logic [79:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);
    localparam int FRAME_AW = $clog2(FRAME_STORE_BYTES);
    localparam int SHORT_AW = $clog2(SHORT_STORE_BYTES);

    logic [1:0]  mode;
    logic [7:0]  b;
    logic [9:0]  ridx;
    assign mode = s_axis_tdata[1:0];
    assign b    = s_axis_tdata[9:2];
    assign ridx = s_axis_tdata[19:10];

    logic [7:0]  stream_ch_reg;
    logic [16:0] max_len_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [6:0]  short_pos_reg, short_pos_next, short_left_reg, short_left_next;
    logic [16:0] frame_pos_reg, frame_pos_next, frame_total_reg, frame_total_next;
    logic [15:0] stream_left_reg, stream_left_next;
    logic [15:0] crc_reg, crc_next;
    logic        crc_phase_reg, crc_phase_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [31:0] mis_reg, mis_next;
    logic [7:0]  len_lo_reg, len_lo_next, chan_reg, chan_next;
    logic [7:0]  tail_lo_reg, tail_lo_next;

    dffd_pkg::stage_t st_reg, st_next;
    logic        out_valid_reg;
    dffd_pkg::result_t out_reg;
    dffd_pkg::result_t st_res;

    logic        adv, take;
    assign adv  = !st_reg.valid || !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign take = s_axis_tvalid && adv;
    assign cfg_ready = 1'b1;

    logic        s_we, f_we;
    logic [SHORT_AW-1:0] s_waddr;
    logic [FRAME_AW-1:0] f_waddr;
    logic [7:0]  s_rdata, f_rdata;

    dffd_stores #(.FRAME_AW(FRAME_AW), .SHORT_AW(SHORT_AW)) u_stores (
        .clk(clk), .s_we(s_we), .s_waddr(s_waddr), .s_wdata(b),
        .f_we(f_we), .f_waddr(f_waddr), .f_wdata(b), .rd_en(take),
        .s_raddr(SHORT_AW'(ridx)), .f_raddr(FRAME_AW'(ridx)),
        .s_rdata(s_rdata), .f_rdata(f_rdata)
    );

    logic [16:0] p, fpos1, len17;
    logic [15:0] crc_upd, want;

    always_comb
    begin
        phase_next       = phase_reg;
        short_pos_next   = short_pos_reg;
        short_left_next  = short_left_reg;
        frame_pos_next   = frame_pos_reg;
        frame_total_next = frame_total_reg;
        stream_left_next = stream_left_reg;
        crc_next         = crc_reg;
        crc_phase_next   = crc_phase_reg;
        crc_low_next     = crc_low_reg;
        mis_next         = mis_reg;
        len_lo_next      = len_lo_reg;
        chan_next        = chan_reg;
        tail_lo_next     = tail_lo_reg;
        st_next          = '0;
        s_we = 1'b0;
        f_we = 1'b0;
        s_waddr = SHORT_AW'(short_pos_reg);
        f_waddr = FRAME_AW'(frame_pos_reg);
        p      = frame_pos_reg;
        fpos1  = frame_pos_reg + 17'd1;
        len17  = {1'b0, b, len_lo_reg};
        crc_upd = dffd_pkg::crc_byte(crc_reg, b);
        want   = {b, tail_lo_reg};

        st_next.valid = take;
        if (take)
        begin
            unique case (mode)
                dffd_pkg::MODE_LINK:
                begin
                    unique case (phase_reg)
                        dffd_pkg::PH_WAIT:
                        begin
                            if (b >= dffd_pkg::SHORT_MIN && b <= dffd_pkg::SHORT_MAX)
                            begin
                                s_we = 1'b1;
                                s_waddr = '0;
                                short_pos_next = 7'd1;
                                short_left_next = b[6:0] - 7'd1;
                                phase_next = dffd_pkg::PH_SHORT;
                            end
                            else if (b == dffd_pkg::SYNC_BYTE)
                            begin
                                f_we = 1'b1;
                                f_waddr = '0;
                                frame_pos_next = 17'd1;
                                frame_total_next = '0;
                                crc_next = dffd_pkg::CRC_SEED;
                                phase_next = dffd_pkg::PH_TRANSPORT;
                            end
                        end
                        dffd_pkg::PH_SHORT:
                        begin
                            s_we = ({25'd0, short_pos_reg} < SHORT_STORE_BYTES);
                            short_pos_next = short_pos_reg + 7'd1;
                            short_left_next = short_left_reg - 7'd1;
                            if (short_left_next == 7'd0)
                            begin
                                st_next.res.event_res = dffd_pkg::EV_SHORT;
                                st_next.res.frame_length = {9'd0, short_pos_next};
                                phase_next = dffd_pkg::PH_WAIT;
                                short_pos_next = '0;
                                short_left_next = '0;
                                frame_pos_next = '0;
                                frame_total_next = '0;
                            end
                        end
                        dffd_pkg::PH_TRANSPORT:
                        begin
                            if ({15'd0, p} >= FRAME_STORE_BYTES)
                            begin
                                st_next.res.event_res = dffd_pkg::EV_ERROR;
                                st_next.res.error_kind = dffd_pkg::ERR_LEN;
                                phase_next = dffd_pkg::PH_WAIT;
                                short_pos_next = '0;
                                short_left_next = '0;
                                frame_pos_next = '0;
                                frame_total_next = '0;
                            end
                            else
                            begin
                                f_we = 1'b1;
                                frame_pos_next = fpos1;
                                if (p == 17'd1) len_lo_next = b;
                                if (p == 17'd3) chan_next = b;
                                if (frame_total_reg != 0 && p + 17'd2 == frame_total_reg)
                                    tail_lo_next = b;
                                if (frame_total_reg == 0 || p + 17'd2 < frame_total_reg)
                                    crc_next = crc_upd;
                                priority if (frame_total_reg == 0 && p == 17'd2
                                             && (len17 < 17'd5
                                                 || len17 + 17'd1 > max_len_reg))
                                begin
                                    st_next.res.event_res = dffd_pkg::EV_ERROR;
                                    st_next.res.error_kind = dffd_pkg::ERR_LEN;
                                    phase_next = dffd_pkg::PH_WAIT;
                                    short_pos_next = '0;
                                    short_left_next = '0;
                                    frame_pos_next = '0;
                                    frame_total_next = '0;
                                end
                                else if (p == 17'd3 && b == stream_ch_reg)
                                begin
                                    stream_left_next = 16'(frame_total_reg
                                                           - dffd_pkg::ENVELOPE);
                                    crc_phase_next = 1'b0;
                                    phase_next = dffd_pkg::PH_STREAM;
                                    st_next.res.event_res = dffd_pkg::EV_SBEGIN;
                                    st_next.res.frame_length = stream_left_next;
                                    st_next.res.channel = b;
                                end
                                else if (p == 17'd3 && {15'd0, frame_total_reg}
                                         > FRAME_STORE_BYTES)
                                begin
                                    st_next.res.event_res = dffd_pkg::EV_ERROR;
                                    st_next.res.error_kind = dffd_pkg::ERR_LEN;
                                    phase_next = dffd_pkg::PH_WAIT;
                                    short_pos_next = '0;
                                    short_left_next = '0;
                                    frame_pos_next = '0;
                                    frame_total_next = '0;
                                end
                                else
                                begin
                                    if (frame_total_reg == 0 && p == 17'd2)
                                        frame_total_next = len17 + 17'd1;
                                    if (frame_total_reg != 0 && fpos1 == frame_total_reg
                                        && frame_total_reg >= dffd_pkg::ENVELOPE)
                                    begin
                                        phase_next = dffd_pkg::PH_WAIT;
                                        short_pos_next = '0;
                                        short_left_next = '0;
                                        frame_pos_next = '0;
                                        frame_total_next = '0;
                                        if (want != crc_reg)
                                        begin
                                            mis_next = mis_reg + 32'd1;
                                            st_next.res.event_res = dffd_pkg::EV_ERROR;
                                            st_next.res.error_kind = dffd_pkg::ERR_CRC;
                                        end
                                        else
                                        begin
                                            st_next.res.event_res =
                                                dffd_pkg::EV_TRANSPORT;
                                            st_next.res.frame_length = 16'(
                                                frame_total_reg - dffd_pkg::ENVELOPE);
                                            st_next.res.channel = chan_reg;
                                        end
                                    end
                                end
                            end
                        end
                        dffd_pkg::PH_STREAM:
                        begin
                            if (stream_left_reg != 0)
                            begin
                                crc_next = crc_upd;
                                stream_left_next = stream_left_reg - 16'd1;
                                st_next.res.event_res = dffd_pkg::EV_SBYTE;
                                st_next.res.channel = chan_reg;
                                st_next.res.stream_byte = b;
                            end
                            else if (!crc_phase_reg)
                            begin
                                crc_low_next = b;
                                crc_phase_next = 1'b1;
                            end
                            else
                            begin
                                crc_phase_next = 1'b0;
                                phase_next = dffd_pkg::PH_WAIT;
                                frame_pos_next = '0;
                                frame_total_next = '0;
                                if ({b, crc_low_reg} == crc_reg)
                                begin
                                    st_next.res.event_res = dffd_pkg::EV_SCOMMIT;
                                    st_next.res.frame_length = 16'(
                                        frame_total_reg - dffd_pkg::ENVELOPE);
                                    st_next.res.channel = chan_reg;
                                end
                                else
                                begin
                                    mis_next = mis_reg + 32'd1;
                                    st_next.res.event_res = dffd_pkg::EV_ERROR;
                                    st_next.res.error_kind = dffd_pkg::ERR_CRC;
                                    short_pos_next = '0;
                                    short_left_next = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                dffd_pkg::MODE_RSHORT:
                begin
                    st_next.rd_short = 1'b1;
                    st_next.rd_zero = ({22'd0, ridx} >= SHORT_STORE_BYTES);
                end
                dffd_pkg::MODE_RFRAME:
                begin
                    st_next.rd_frame = 1'b1;
                    st_next.rd_zero = ({22'd0, ridx} >= FRAME_STORE_BYTES);
                end
                dffd_pkg::MODE_GAP:
                begin
                    if (phase_reg != dffd_pkg::PH_WAIT)
                    begin
                        phase_next = dffd_pkg::PH_WAIT;
                        short_pos_next = '0;
                        short_left_next = '0;
                        frame_pos_next = '0;
                        frame_total_next = '0;
                    end
                end
                default: ;
            endcase
            st_next.res.crc_mismatch_count = mis_next;
        end
    end

    // merge store read data into the staged result
    always_comb
    begin
        st_res = st_reg.res;
        if (!st_reg.rd_zero && st_reg.rd_short)
            st_res.read_data = s_rdata;
        if (!st_reg.rd_zero && st_reg.rd_frame)
            st_res.read_data = f_rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_ch_reg   <= '0;
            max_len_reg     <= 17'd1024;
            phase_reg       <= dffd_pkg::PH_WAIT;
            short_pos_reg   <= '0;
            short_left_reg  <= '0;
            frame_pos_reg   <= '0;
            frame_total_reg <= '0;
            stream_left_reg <= '0;
            crc_reg         <= dffd_pkg::CRC_SEED;
            crc_phase_reg   <= 1'b0;
            crc_low_reg     <= '0;
            mis_reg         <= '0;
            len_lo_reg      <= '0;
            chan_reg        <= '0;
            tail_lo_reg     <= '0;
            st_reg          <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == dffd_pkg::CFG_STREAM_CH)
                    stream_ch_reg <= cfg_data[7:0];
                else
                    max_len_reg <= cfg_data;
            end
            phase_reg       <= phase_next;
            short_pos_reg   <= short_pos_next;
            short_left_reg  <= short_left_next;
            frame_pos_reg   <= frame_pos_next;
            frame_total_reg <= frame_total_next;
            stream_left_reg <= stream_left_next;
            crc_reg         <= crc_next;
            crc_phase_reg   <= crc_phase_next;
            crc_low_reg     <= crc_low_next;
            mis_reg         <= mis_next;
            len_lo_reg      <= len_lo_next;
            chan_reg        <= chan_next;
            tail_lo_reg     <= tail_lo_next;
            if (adv)
            begin
                st_reg <= st_next;
                if (st_reg.valid)
                begin
                    out_valid_reg <= 1'b1;
                    out_reg <= st_res;
                end
                else if (m_axis_tready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_reg.crc_mismatch_count, out_reg.read_data,
                            out_reg.stream_byte, out_reg.channel, out_reg.frame_length,
                            out_reg.error_kind, out_reg.event_res};
endmodule
